// File: rtl/spd_pkg.sv
package spd_pkg;

	localparam int ALPHABET = 256;
	localparam int INNER    = ALPHABET + 1;
	localparam int ALLNODES = 2 * ALPHABET + 2;
	localparam int NODE_W   = $clog2(ALLNODES + 1);
	localparam int PAR_W    = $clog2(INNER);
	localparam int ALL_W    = $clog2(ALLNODES);
	localparam int ROW_W    = 2 * NODE_W;
	localparam int SYM_W    = 8;
	localparam int BITS_W   = $clog2(SYM_W + 1);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_BIT_RD,
		OP_BIT_EV,
		OP_SP_START,
		OP_SP_UP,
		OP_SP_GR,
		OP_SP_GC,
		OP_SP_UCRD,
		OP_SP_UC,
		OP_SP_PO,
		OP_TRUNC,
		OP_PUSH,
		OP_FLUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic bits_zero;
		logic is_leaf;
		logic sp_stop;
		logic xfer_ok;
		logic last;
		logic pend_valid;
	} dp_stat_t;

endpackage

// File: rtl/spd_ram.sv
module spd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/spd_ctrl.sv
module spd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              first_of_zone,
	output logic              in_stall,
	input  spd_pkg::dp_stat_t stat,
	output spd_pkg::dp_cmd_t  cmd
);

	import spd_pkg::*;

	typedef enum logic [4:0] {
		S_CLR_BOOT,
		S_IDLE,
		S_CLR_ZONE,
		S_BIT_RD,
		S_BIT_EV,
		S_RES_LEAF,
		S_SP_START,
		S_SP_UP,
		S_SP_GR,
		S_SP_GC,
		S_SP_UCRD,
		S_SP_UC,
		S_SP_PO,
		S_SP_END,
		S_TRUNC,
		S_RES_TRUNC,
		S_FLUSH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			S_CLR_BOOT: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = first_of_zone ? S_CLR_ZONE : S_BIT_RD;
				end
			end
			S_CLR_ZONE: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_done) begin
					state_d = S_BIT_RD;
				end
			end
			S_BIT_RD: begin
				if (stat.bits_zero) begin
					state_d = stat.last ? S_TRUNC : S_FLUSH;
				end else begin
					cmd.op  = OP_BIT_RD;
					state_d = S_BIT_EV;
				end
			end
			S_BIT_EV: begin
				cmd.op  = OP_BIT_EV;
				state_d = stat.is_leaf ? S_RES_LEAF : S_BIT_RD;
			end
			S_RES_LEAF: begin
				cmd.op = OP_PUSH;
				if (stat.xfer_ok) begin
					state_d = S_SP_START;
				end
			end
			S_SP_START: begin
				cmd.op  = OP_SP_START;
				state_d = stat.sp_stop ? S_SP_END : S_SP_UP;
			end
			S_SP_UP: begin
				cmd.op  = OP_SP_UP;
				state_d = stat.sp_stop ? S_SP_END : S_SP_GR;
			end
			S_SP_GR: begin
				cmd.op  = OP_SP_GR;
				state_d = stat.sp_stop ? S_SP_END : S_SP_GC;
			end
			S_SP_GC: begin
				cmd.op  = OP_SP_GC;
				state_d = S_SP_UCRD;
			end
			S_SP_UCRD: begin
				cmd.op  = OP_SP_UCRD;
				state_d = S_SP_UC;
			end
			S_SP_UC: begin
				cmd.op  = OP_SP_UC;
				state_d = S_SP_PO;
			end
			S_SP_PO: begin
				cmd.op  = OP_SP_PO;
				state_d = stat.sp_stop ? S_SP_END : S_SP_START;
			end
			S_SP_END: begin
				state_d = stat.last ? S_FLUSH : S_BIT_RD;
			end
			S_TRUNC: begin
				cmd.op  = OP_TRUNC;
				state_d = S_RES_TRUNC;
			end
			S_RES_TRUNC: begin
				cmd.op = OP_PUSH;
				if (stat.xfer_ok) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.op = OP_FLUSH;
				if (stat.xfer_ok) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	// no word may linger in the holding register once a byte is finished
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !stat.pend_valid)
		else $error("word left pending at idle");

	// a zone start always sweeps the tree before any bit is walked
	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && first_of_zone) |=> state_q == S_CLR_ZONE)
		else $error("zone start without tree rebuild");
`endif

endmodule

// File: rtl/spd_datapath.sv
module spd_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spd_pkg::dp_cmd_t          cmd,
	output spd_pkg::dp_stat_t         stat,
	input  logic [7:0]                in_byte,
	input  logic                      first_of_zone,
	input  logic                      last_of_zone,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [spd_pkg::SYM_W-1:0] out_byte,
	output logic                      truncated,
	output logic                      last_of_run
);

	import spd_pkg::*;

	// bit walk state
	logic [SYM_W-1:0]  buf_q;
	logic [BITS_W-1:0] bits_q;
	logic              last_q;
	logic              bit_q;
	logic [PAR_W-1:0]  walk_q;

	// splay state
	logic [NODE_W-1:0] node_q;
	logic [PAR_W-1:0]  up_q;
	logic [PAR_W-1:0]  grand_q;
	logic [NODE_W-1:0] other_q;
	logic [NODE_W-1:0] guard_q;
	logic [NODE_W-1:0] clr_q;

	// result staging
	logic [SYM_W-1:0]  res_byte_q;
	logic              res_trunc_q;
	logic              pend_valid_q;
	logic [SYM_W-1:0]  pend_byte_q;
	logic              pend_trunc_q;
	logic              out_valid_q;
	logic [SYM_W-1:0]  out_byte_q;
	logic              out_trunc_q;
	logic              out_last_q;

	// tables
	logic              c_we;
	logic [PAR_W-1:0]  c_waddr;
	logic [ROW_W-1:0]  c_wdata;
	logic [PAR_W-1:0]  c_raddr;
	logic [ROW_W-1:0]  c_rdata;
	logic              p_we;
	logic [ALL_W-1:0]  p_waddr;
	logic [PAR_W-1:0]  p_wdata;
	logic [ALL_W-1:0]  p_raddr;
	logic [PAR_W-1:0]  p_rdata;

	logic [NODE_W-1:0] c_left;
	logic [NODE_W-1:0] c_right;
	logic [NODE_W-1:0] bit_next;
	logic [NODE_W-1:0] guard_inc;
	logic              is_leaf;
	logic              sp_stop;
	logic              out_free;
	logic              xfer_ok;
	logic              out_load;
	logic              out_load_last;

	spd_ram #(.WIDTH(ROW_W), .DEPTH(INNER)) u_child (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	spd_ram #(.WIDTH(PAR_W), .DEPTH(ALLNODES)) u_parent (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	assign c_left    = c_rdata[NODE_W-1:0];
	assign c_right   = c_rdata[ROW_W-1:NODE_W];
	assign bit_next  = bit_q ? c_right : c_left;
	assign is_leaf   = bit_next >= NODE_W'(INNER);
	assign guard_inc = guard_q + NODE_W'(1);
	assign out_free  = !out_valid_q || !out_stall;
	assign xfer_ok   = !pend_valid_q || out_free;

	always_comb begin
		unique case (cmd.op)
			OP_SP_START: sp_stop = node_q >= NODE_W'(ALLNODES);
			OP_SP_UP:    sp_stop = (p_rdata == '0) || (NODE_W'(p_rdata) >= NODE_W'(INNER));
			OP_SP_GR:    sp_stop = NODE_W'(p_rdata) >= NODE_W'(INNER);
			OP_SP_PO:    sp_stop = (grand_q == '0) || (guard_inc == NODE_W'(ALLNODES));
			default:     sp_stop = 1'b0;
		endcase
	end

	assign stat.clr_done   = clr_q == NODE_W'(ALLNODES - 1);
	assign stat.bits_zero  = bits_q == '0;
	assign stat.is_leaf    = is_leaf;
	assign stat.sp_stop    = sp_stop;
	assign stat.xfer_ok    = xfer_ok;
	assign stat.last       = last_q;
	assign stat.pend_valid = pend_valid_q;

	// table port muxes
	always_comb begin
		c_we    = 1'b0;
		c_waddr = clr_q[PAR_W-1:0];
		c_wdata = {NODE_W'({clr_q, 1'b1}), NODE_W'({clr_q, 1'b0})};
		c_raddr = walk_q;
		p_we    = 1'b0;
		p_waddr = clr_q[ALL_W-1:0];
		p_wdata = PAR_W'(clr_q >> 1);
		p_raddr = node_q[ALL_W-1:0];
		unique case (cmd.op)
			OP_CLEAR: begin
				c_we = clr_q < NODE_W'(INNER);
				p_we = 1'b1;
			end
			OP_SP_UP: begin
				p_raddr = ALL_W'(p_rdata);
			end
			OP_SP_GR: begin
				c_raddr = p_rdata;
			end
			OP_SP_GC: begin
				c_we    = 1'b1;
				c_waddr = grand_q;
				if (NODE_W'(up_q) == c_left) begin
					c_wdata = {node_q, c_left};
				end else begin
					c_wdata = {c_right, node_q};
				end
			end
			OP_SP_UCRD: begin
				c_raddr = up_q;
			end
			OP_SP_UC: begin
				c_we    = 1'b1;
				c_waddr = up_q;
				if (c_left == node_q) begin
					c_wdata = {c_right, other_q};
				end else begin
					c_wdata = {other_q, c_left};
				end
				p_we    = 1'b1;
				p_waddr = node_q[ALL_W-1:0];
				p_wdata = grand_q;
			end
			OP_SP_PO: begin
				p_we    = other_q < NODE_W'(ALLNODES);
				p_waddr = other_q[ALL_W-1:0];
				p_wdata = up_q;
			end
			default: begin
			end
		endcase
	end

	assign out_load      = ((cmd.op == OP_PUSH) && pend_valid_q && out_free) ||
		((cmd.op == OP_FLUSH) && pend_valid_q && out_free);
	assign out_load_last = cmd.op == OP_FLUSH;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q       <= '0;
			walk_q       <= '0;
			clr_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_LOAD: begin
					bits_q <= BITS_W'(SYM_W);
					last_q <= last_of_zone;
					if (first_of_zone) begin
						walk_q <= '0;
					end
				end
				OP_CLEAR: begin
					clr_q <= (clr_q == NODE_W'(ALLNODES - 1)) ? '0 : clr_q + NODE_W'(1);
				end
				OP_BIT_RD: begin
					bits_q <= bits_q - BITS_W'(1);
				end
				OP_BIT_EV: begin
					walk_q <= is_leaf ? '0 : bit_next[PAR_W-1:0];
				end
				OP_TRUNC: begin
					walk_q <= '0;
				end
				OP_PUSH: begin
					if (xfer_ok) begin
						pend_valid_q <= 1'b1;
					end
				end
				OP_FLUSH: begin
					if (xfer_ok) begin
						pend_valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q  <= pend_byte_q;
			out_trunc_q <= pend_trunc_q;
			out_last_q  <= out_load_last;
		end
		unique case (cmd.op)
			OP_LOAD: begin
				buf_q <= in_byte;
			end
			OP_BIT_RD: begin
				bit_q <= buf_q[SYM_W-1];
				buf_q <= {buf_q[SYM_W-2:0], 1'b0};
			end
			OP_BIT_EV: begin
				if (is_leaf) begin
					node_q      <= bit_next;
					res_byte_q  <= SYM_W'(bit_next - NODE_W'(INNER));
					res_trunc_q <= 1'b0;
					guard_q     <= '0;
				end
			end
			OP_SP_UP: begin
				up_q <= p_rdata;
			end
			OP_SP_GR: begin
				grand_q <= p_rdata;
			end
			OP_SP_GC: begin
				other_q <= (NODE_W'(up_q) == c_left) ? c_right : c_left;
			end
			OP_SP_PO: begin
				node_q  <= NODE_W'(grand_q);
				guard_q <= guard_inc;
			end
			OP_TRUNC: begin
				res_byte_q  <= SYM_W'(walk_q);
				res_trunc_q <= 1'b1;
			end
			OP_PUSH: begin
				if (xfer_ok) begin
					pend_byte_q  <= res_byte_q;
					pend_trunc_q <= res_trunc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign truncated   = out_trunc_q;
	assign last_of_run = out_last_q;

`ifndef NO_ASSERTIONS
	// the output register is only refilled when its word leaves or is absent
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten");

	// bit count never exceeds one byte
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= BITS_W'(SYM_W))
		else $error("bit count out of range");

	// rotations only rewrite inner nodes
	a_grand_inner: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SP_GC || cmd.op == OP_SP_UC) |->
		(NODE_W'(grand_q) < NODE_W'(INNER) && NODE_W'(up_q) < NODE_W'(INNER)))
		else $error("rotation on a leaf index");
`endif

endmodule

// File: rtl/splay_prefix_decoder_unit.sv
// Splay-tree prefix decoder: one compressed byte per input word, bits taken most
// significant first, up to eight decoded words out per byte, the final one flagged
// last_of_run. A byte is taken from idle, and each bit walked is read and then
// evaluated. Once the bits run out the byte hands off its final word; a last byte
// goes on to that hand-off as soon as it completes a symbol.
// Every decoded symbol is staged and then splayed; each semi-rotation of the splay
// (bounded by the tree depth) steps through the start, up, grandparent, grandparent
// child, child read, child write and parent pointer states, and a closing state
// ends the splay. A last byte that completes no symbol adds a truncated word. The
// child and parent tables each have a single read port.
// A byte with first_of_zone first rebuilds the tree in a sweep over all 514 parent
// entries and the child table, and the same sweep runs once after reset before the
// first byte is taken. Decoded words wait in a holding register and an output
// register, so a stalled output holds up decoding when a third word is ready behind
// them, or when the final word of a byte must move to the output register. The next
// byte is taken only after that final word has moved to the output register.
module splay_prefix_decoder_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                in_byte,
	input  logic                      first_of_zone,
	input  logic                      last_of_zone,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [spd_pkg::SYM_W-1:0] out_byte,
	output logic                      truncated,
	output logic                      last_of_run
);

	import spd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	spd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.first_of_zone (first_of_zone),
		.in_stall      (in_stall),
		.stat          (stat),
		.cmd           (cmd)
	);

	spd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_byte       (in_byte),
		.first_of_zone (first_of_zone),
		.last_of_zone  (last_of_zone),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.truncated     (truncated),
		.last_of_run   (last_of_run)
	);

endmodule
